// ===== hw/rtl/prfa_pkg.sv =====
// ----------------------------------------------------------------------------
// prfa_pkg
// Shared types and constants for the pairwise repulsion force accumulator.
// ----------------------------------------------------------------------------
package prfa_pkg;

    localparam int FRAC_BITS = 20;
    localparam int CRD_W     = 24;   // coordinate width
    localparam int RAD_W     = 23;   // radius width
    localparam int DD_W      = 24;   // radius sum width
    localparam int DX_W      = 26;   // wrapped delta width
    localparam int DSQ_W     = 52;   // squared distance width
    localparam int DIST_W    = 26;   // distance width
    localparam int DIR_W     = 22;   // direction width
    localparam int QUO_W     = 21;   // divider quotient width
    localparam int SUM_W     = 32;
    localparam int MIN_W     = 25;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 23;
    localparam int NEAR_DEN  = 1000;

    localparam logic [CFG_IDX_W-1:0] CFG_BOX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TORUS_MODE = 2'd2;

    typedef struct packed {
        logic signed [DX_W-1:0]  dx;
        logic signed [DX_W-1:0]  dy;
        logic [DD_W-1:0]         rsum;
        logic signed [DIR_W-1:0] rx;
        logic signed [DIR_W-1:0] ry;
        logic                    self_pair;
        logic                    last;
    } pair_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_SQRT,
        ST_CHECK,
        ST_DIVR,
        ST_FORCE,
        ST_DIVX,
        ST_DIVY,
        ST_MULX,
        ST_MULY,
        ST_FINISH
    } back_state_t;

endpackage

// ===== hw/rtl/prfa_front.sv =====
// ----------------------------------------------------------------------------
// prfa_front
// Holds configuration, forms the wrapped neighbor vector and radius sum.
// ----------------------------------------------------------------------------
module prfa_front
    import prfa_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    input  logic signed [CRD_W-1:0]     target_x,
    input  logic signed [CRD_W-1:0]     target_y,
    input  logic [RAD_W-1:0]            target_radius,
    input  logic signed [CRD_W-1:0]     neighbor_x,
    input  logic signed [CRD_W-1:0]     neighbor_y,
    input  logic [RAD_W-1:0]            neighbor_radius,
    input  logic                        is_self,
    input  logic signed [DIR_W-1:0]     random_dir_x,
    input  logic signed [DIR_W-1:0]     random_dir_y,
    input  logic                        last_neighbor,
    output pair_t                       pair
);

    logic [CFG_W-1:0] box_w_reg;
    logic [CFG_W-1:0] box_h_reg;
    logic             torus_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_w_reg <= CFG_W'(1 << FRAC_BITS);
            box_h_reg <= CFG_W'(1 << FRAC_BITS);
            torus_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BOX_WIDTH:  box_w_reg <= cfg_data;
                CFG_BOX_HEIGHT: box_h_reg <= cfg_data;
                CFG_TORUS_MODE: torus_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    function automatic logic signed [DX_W-1:0] wrap(
        input logic signed [CRD_W-1:0] a,
        input logic signed [CRD_W-1:0] b,
        input logic [CFG_W-1:0]        span,
        input logic                    torus
    );
        logic signed [DX_W-1:0] c;
        logic [DX_W-1:0]        mag;
        logic signed [DX_W-1:0] sp;
        c   = DX_W'(a) - DX_W'(b);
        mag = c[DX_W-1] ? DX_W'(-c) : DX_W'(c);
        sp  = DX_W'({1'b0, span});
        if (torus && ({mag, 1'b0} > {{(DX_W-CFG_W+1){1'b0}}, span}))
            c = c[DX_W-1] ? c + sp : c - sp;
        return c;
    endfunction

    always_comb
    begin
        pair.dx        = wrap(neighbor_x, target_x, box_w_reg, torus_reg);
        pair.dy        = wrap(neighbor_y, target_y, box_h_reg, torus_reg);
        pair.rsum      = DD_W'(target_radius) + DD_W'(neighbor_radius);
        pair.rx        = random_dir_x;
        pair.ry        = random_dir_y;
        pair.self_pair = is_self;
        pair.last      = last_neighbor;
    end

endmodule

// ===== hw/rtl/prfa_queue.sv =====
// ----------------------------------------------------------------------------
// prfa_queue
// Two-entry queue of classified pairs between front and back.
// ----------------------------------------------------------------------------
module prfa_queue
    import prfa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  pair_t wr_pair,
    input  logic  pop,
    output pair_t rd_pair,
    output logic  full,
    output logic  empty
);

    pair_t       mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_pair;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    assign rd_pair = mem_reg[rd_ptr_reg];
    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3) else $error("queue count out of range");

endmodule

// ===== hw/rtl/prfa_back.sv =====
// ----------------------------------------------------------------------------
// prfa_back
// Sequencer with shared square root and divider; accumulates the force.
// ----------------------------------------------------------------------------
module prfa_back
    import prfa_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_empty,
    input  pair_t                    q_pair,
    output logic                     q_pop,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [SUM_W-1:0]  force_x,
    output logic signed [SUM_W-1:0]  force_y,
    output logic [MIN_W-1:0]         min_distance,
    output logic                     min_valid
);

    localparam int DVN_W = DX_W + FRAC_BITS + 1;  // dividend width
    localparam int REM_W = DIST_W + 1;
    localparam int CNT_W = 5;
    localparam logic signed [SUM_W+1:0] SAT_HI = $signed({3'b000, {(SUM_W-1){1'b1}}});
    localparam logic signed [SUM_W+1:0] SAT_LO = $signed({3'b111, {(SUM_W-1){1'b0}}});

    back_state_t              state_reg, state_next;
    pair_t                    ent_reg, ent_next;
    logic [DSQ_W-1:0]         v_reg, v_next;
    logic [DSQ_W-1:0]         r_reg, r_next;
    logic [DSQ_W-1:0]         b_reg, b_next;
    logic [DIST_W-1:0]        d_reg, d_next;
    logic                     near_reg, near_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [QUO_W-1:0]         dvn_reg, dvn_next;
    logic [QUO_W-1:0]         quo_reg, quo_next;
    logic [DIST_W-1:0]        dvs_reg, dvs_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [QUO_W-1:0]         f_reg, f_next;
    logic signed [DIR_W-1:0]  ux_reg, ux_next;
    logic signed [DIR_W-1:0]  uy_reg, uy_next;
    logic signed [SUM_W-1:0]  sx_reg, sx_next;
    logic signed [SUM_W-1:0]  sy_reg, sy_next;
    logic [MIN_W-1:0]         least_reg, least_next;
    logic                     seen_reg, seen_next;
    logic                     ov_reg, ov_next;
    logic signed [SUM_W-1:0]  fx_reg, fx_next;
    logic signed [SUM_W-1:0]  fy_reg, fy_next;
    logic [MIN_W-1:0]         md_reg, md_next;
    logic                     mv_reg, mv_next;

    // Round f*u to nearest (halves away from zero) and subtract with saturation.
    function automatic logic signed [SUM_W-1:0] acc_sub(
        input logic signed [SUM_W-1:0] s,
        input logic [QUO_W-1:0]        f,
        input logic signed [DIR_W-1:0] u
    );
        logic signed [QUO_W+DIR_W:0]   p;
        logic [QUO_W+DIR_W:0]          mag;
        logic [QUO_W+DIR_W:0]          t;
        logic signed [SUM_W+1:0]       term;
        logic signed [SUM_W+1:0]       diff;
        p    = $signed({1'b0, f}) * (QUO_W+DIR_W+1)'(u);
        mag  = p[QUO_W+DIR_W] ? (QUO_W+DIR_W+1)'(-p) : (QUO_W+DIR_W+1)'(p);
        t    = (mag + (QUO_W+DIR_W+1)'(1 << (FRAC_BITS-1))) >> FRAC_BITS;
        term = p[QUO_W+DIR_W] ? -(SUM_W+2)'(t) : (SUM_W+2)'(t);
        diff = (SUM_W+2)'(s) - term;
        if (diff > SAT_HI)
            return SAT_HI[SUM_W-1:0];
        else if (diff < SAT_LO)
            return SAT_LO[SUM_W-1:0];
        return diff[SUM_W-1:0];
    endfunction

    logic [REM_W-1:0]         trial;
    logic                     qbit;
    logic [DSQ_W:0]           rb;
    logic signed [2*DX_W-1:0] sq;
    logic [DIST_W-1:0]        d_new;
    logic [DIST_W+10-1:0]     d_k;
    logic [QUO_W-1:0]         g;
    logic [2*QUO_W-1:0]       gg;
    logic [DX_W-1:0]          ax;
    logic [DX_W-1:0]          ay;
    logic signed [DIR_W-1:0]  q_signed;
    logic                     out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sx_reg    <= '0;
            sy_reg    <= '0;
            least_reg <= '0;
            seen_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            least_reg <= least_next;
            seen_reg  <= seen_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg  <= ent_next;
        v_reg    <= v_next;
        r_reg    <= r_next;
        b_reg    <= b_next;
        d_reg    <= d_next;
        near_reg <= near_next;
        rem_reg  <= rem_next;
        dvn_reg  <= dvn_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        cnt_reg  <= cnt_next;
        f_reg    <= f_next;
        ux_reg   <= ux_next;
        uy_reg   <= uy_next;
        fx_reg   <= fx_next;
        fy_reg   <= fy_next;
        md_reg   <= md_next;
        mv_reg   <= mv_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ent_next   = ent_reg;
        v_next     = v_reg;
        r_next     = r_reg;
        b_next     = b_reg;
        d_next     = d_reg;
        near_next  = near_reg;
        rem_next   = rem_reg;
        dvn_next   = dvn_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        cnt_next   = cnt_reg;
        f_next     = f_reg;
        ux_next    = ux_reg;
        uy_next    = uy_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        least_next = least_reg;
        seen_next  = seen_reg;
        fx_next    = fx_reg;
        fy_next    = fy_reg;
        md_next    = md_reg;
        mv_next    = mv_reg;
        q_pop      = 1'b0;
        out_free   = !ov_reg || !out_stall;
        ov_next    = ov_reg && out_stall;

        // divider step
        trial    = {rem_reg[DIST_W-1:0], dvn_reg[QUO_W-1]};
        qbit     = (trial >= {1'b0, dvs_reg});
        // square root step
        rb       = {1'b0, r_reg} + {1'b0, b_reg};
        sq       = ent_reg.dx * ent_reg.dx;
        d_new    = r_reg[DIST_W-1:0];
        d_k      = (DIST_W+10)'(d_new) * (DIST_W+10)'(NEAR_DEN);
        g        = QUO_W'(1 << FRAC_BITS) - quo_reg;
        gg       = g * g;
        ax       = ent_reg.dx[DX_W-1] ? DX_W'(-ent_reg.dx) : DX_W'(ent_reg.dx);
        ay       = ent_reg.dy[DX_W-1] ? DX_W'(-ent_reg.dy) : DX_W'(ent_reg.dy);
        // quotient including the bit of the current step
        q_signed = {1'b0, quo_reg[QUO_W-2:0], qbit};

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    ent_next   = q_pair;
                    state_next = q_pair.self_pair ? ST_FINISH : ST_SQX;
                end
            end
            ST_SQX:
            begin
                v_next     = DSQ_W'($unsigned(sq));
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                sq         = ent_reg.dy * ent_reg.dy;
                v_next     = v_reg + DSQ_W'($unsigned(sq));
                r_next     = '0;
                b_next     = DSQ_W'(1) << (DSQ_W - 2);
                cnt_next   = CNT_W'(DSQ_W/2 - 1);
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if ({1'b0, v_reg} >= rb)
                begin
                    v_next = v_reg - rb[DSQ_W-1:0];
                    r_next = (r_reg >> 1) + b_reg;
                end
                else
                    r_next = r_reg >> 1;
                b_next = b_reg >> 2;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                d_next    = d_new;
                near_next = (d_new == '0) || (d_k < (DIST_W+10)'(ent_reg.rsum));
                if (!seen_reg || (d_new < DIST_W'(least_reg)))
                begin
                    least_next = d_new[MIN_W-1:0];
                    seen_next  = 1'b1;
                end
                if (d_new > DIST_W'(ent_reg.rsum))
                    state_next = ST_FINISH;
                else if (ent_reg.rsum == '0)
                begin
                    quo_next   = '0;
                    state_next = ST_FORCE;
                end
                else
                begin
                    rem_next   = REM_W'(d_new >> 1);
                    dvn_next   = {d_new[0], {(QUO_W-1){1'b0}}};
                    dvs_next   = DIST_W'(ent_reg.rsum);
                    quo_next   = '0;
                    cnt_next   = CNT_W'(QUO_W - 1);
                    state_next = ST_DIVR;
                end
            end
            ST_DIVR, ST_DIVX, ST_DIVY:
            begin
                rem_next = qbit ? trial - {1'b0, dvs_reg} : trial;
                dvn_next = dvn_reg << 1;
                quo_next = {quo_reg[QUO_W-2:0], qbit};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    case (state_reg)
                        ST_DIVR: state_next = ST_FORCE;
                        ST_DIVX:
                        begin
                            ux_next    = ent_reg.dx[DX_W-1] ? -q_signed : q_signed;
                            rem_next   = REM_W'(ay >> 1);
                            dvn_next   = {ay[0], {(QUO_W-1){1'b0}}};
                            quo_next   = '0;
                            cnt_next   = CNT_W'(QUO_W - 1);
                            state_next = ST_DIVY;
                        end
                        default:
                        begin
                            uy_next    = ent_reg.dy[DX_W-1] ? -q_signed : q_signed;
                            state_next = ST_MULX;
                        end
                    endcase
                end
            end
            ST_FORCE:
            begin
                f_next = QUO_W'((gg + (2*QUO_W)'(1 << (FRAC_BITS-1))) >> FRAC_BITS);
                if (near_reg)
                begin
                    ux_next    = ent_reg.rx;
                    uy_next    = ent_reg.ry;
                    state_next = ST_MULX;
                end
                else
                begin
                    rem_next   = REM_W'(ax >> 1);
                    dvn_next   = {ax[0], {(QUO_W-1){1'b0}}};
                    dvs_next   = d_reg;
                    quo_next   = '0;
                    cnt_next   = CNT_W'(QUO_W - 1);
                    state_next = ST_DIVX;
                end
            end
            ST_MULX:
            begin
                sx_next    = acc_sub(sx_reg, f_reg, ux_reg);
                state_next = ST_MULY;
            end
            ST_MULY:
            begin
                sy_next    = acc_sub(sy_reg, f_reg, uy_reg);
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!ent_reg.last)
                    state_next = ST_IDLE;
                else if (out_free)
                begin
                    ov_next    = 1'b1;
                    fx_next    = sx_reg;
                    fy_next    = sy_reg;
                    md_next    = seen_reg ? least_reg : '0;
                    mv_next    = seen_reg;
                    sx_next    = '0;
                    sy_next    = '0;
                    least_next = '0;
                    seen_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid    = ov_reg;
    assign force_x      = fx_reg;
    assign force_y      = fy_reg;
    assign min_distance = md_reg;
    assign min_valid    = mv_reg;

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_IDLE && !q_empty)) else $error("pop outside idle");

    a_clear_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && ent_reg.last && out_free)
        |=> (sx_reg == '0 && sy_reg == '0 && !seen_reg && out_valid))
        else $error("sums not cleared on emit");

    a_min_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !min_valid) |-> (min_distance == '0))
        else $error("empty minimum not zero");

endmodule

// ===== hw/rtl/pairwise_repulsion_force_accumulator.sv =====
// ----------------------------------------------------------------------------
// pairwise_repulsion_force_accumulator
// Accumulates short-range repulsion on a target point over its neighbors.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_stall   | target_*, neighbor_*, is_self, random_dir_*,
//          |                       | last_neighbor
//  out     | out_valid / out_stall | force_x, force_y, min_distance, min_valid
//  cfg     | cfg_we                | cfg_index, cfg_data
//
//  An item out of reach runs only the 26 steps of the square root; when a
//  force is applied, up to three 21-step divisions follow in the shared
//  restoring divider, two of them only when the pair is not near. A self
//  pair skips both. Reset clears the sums, the minimum and the queue; the
//  box is 1.0 x 1.0 with torus mode off. The front accepts up to two items
//  while the back is busy; in_stall rises when the queue is full. A held
//  result stalls only the last item of the next target.
// ----------------------------------------------------------------------------
module pairwise_repulsion_force_accumulator
    import prfa_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    // input channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [CRD_W-1:0]  target_x,
    input  logic signed [CRD_W-1:0]  target_y,
    input  logic [RAD_W-1:0]         target_radius,
    input  logic signed [CRD_W-1:0]  neighbor_x,
    input  logic signed [CRD_W-1:0]  neighbor_y,
    input  logic [RAD_W-1:0]         neighbor_radius,
    input  logic                     is_self,
    input  logic signed [DIR_W-1:0]  random_dir_x,
    input  logic signed [DIR_W-1:0]  random_dir_y,
    input  logic                     last_neighbor,
    // output channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [SUM_W-1:0]  force_x,
    output logic signed [SUM_W-1:0]  force_y,
    output logic [MIN_W-1:0]         min_distance,
    output logic                     min_valid
);

    pair_t front_pair;
    pair_t head_pair;
    logic  q_full;
    logic  q_empty;
    logic  q_pop;
    logic  push;

    // Front: wrap the neighbor vector and form the radius sum as the item arrives.
    prfa_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .target_x        (target_x),
        .target_y        (target_y),
        .target_radius   (target_radius),
        .neighbor_x      (neighbor_x),
        .neighbor_y      (neighbor_y),
        .neighbor_radius (neighbor_radius),
        .is_self         (is_self),
        .random_dir_x    (random_dir_x),
        .random_dir_y    (random_dir_y),
        .last_neighbor   (last_neighbor),
        .pair            (front_pair)
    );

    // Accept an item whenever the queue has room.
    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    prfa_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_pair (front_pair),
        .pop     (q_pop),
        .rd_pair (head_pair),
        .full    (q_full),
        .empty   (q_empty)
    );

    // Back: distance, force and accumulation, one pair at a time.
    prfa_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_pair       (head_pair),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .force_x      (force_x),
        .force_y      (force_y),
        .min_distance (min_distance),
        .min_valid    (min_valid)
    );

endmodule
